// File: rtl/core/sct_pkg.sv
// Shared types and constants for the sparse chunked tile store.
// Used by the channel interfaces and by every module in rtl/core.
package sct_pkg;

    // Fixed field widths of the channels and configuration registers.
    localparam int COORD_W    = 32;
    localparam int CNT_W      = 7;
    localparam int SHIFT_W    = 3;
    localparam int PORT_VAL_W = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Widths of the linear chunk index math: t = cz * count_y + cy, then
    // lin = t * count_x + cx.
    localparam int T_W   = 2 * CNT_W + 1;
    localparam int LIN_W = 3 * CNT_W + 2;

    // Default geometry handed to the top-level parameters.
    localparam int DEF_MAX_CHUNK_SHIFT = 4;
    localparam int DEF_MAX_CHUNKS      = 64;
    localparam int DEF_VALUE_BITS      = 8;

    // Command field encoding.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_RANGE   = 2'd1,
        ST_UNALLOC = 2'd2
    } status_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHUNK_SHIFT = 3'd0,
        CFG_COUNT_X     = 3'd1,
        CFG_COUNT_Y     = 3'd2,
        CFG_COUNT_Z     = 3'd3,
        CFG_FILL_VALUE  = 3'd4
    } cfg_idx_t;

    // Reset values of the configuration registers.
    localparam logic [SHIFT_W-1:0]    RST_CHUNK_SHIFT = 3'd4;
    localparam logic [CNT_W-1:0]      RST_COUNT       = 7'd4;
    localparam logic [PORT_VAL_W-1:0] RST_FILL_VALUE  = 8'd0;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [SHIFT_W-1:0]    chunk_shift;
        logic [CNT_W-1:0]      count_x;
        logic [CNT_W-1:0]      count_y;
        logic [CNT_W-1:0]      count_z;
        logic [PORT_VAL_W-1:0] fill_value;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic split;
        logic lin_load;
        logic tile_write;
        logic fill_start;
        logic fill_write;
        logic mem_read;
        logic push_out;
    } sct_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic oor;
        logic is_write;
        logic alloc_hit;
        logic fill_last;
        logic out_free;
    } sct_sts_t;

endpackage

// File: rtl/core/sct_ifs.sv
// Valid/ready channel interfaces of the sparse chunked tile store:
// request beats, result beats and configuration writes. Depends on sct_pkg.
interface sct_req_if;
    import sct_pkg::*;

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [COORD_W-1:0] tile_x;
    logic [COORD_W-1:0] tile_y;
    logic [COORD_W-1:0] tile_z;
    logic [PORT_VAL_W-1:0] write_value;

    modport source (output valid, cmd, tile_x, tile_y, tile_z, write_value, input ready);
    modport sink   (input valid, cmd, tile_x, tile_y, tile_z, write_value, output ready);
endinterface

interface sct_rsp_if;
    import sct_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [PORT_VAL_W-1:0] read_value;
    logic [STATUS_W-1:0]   status;

    modport source (output valid, read_value, status, input ready);
    modport sink   (input valid, read_value, status, output ready);
endinterface

interface sct_cfg_if;
    import sct_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/sct_cfg_regs.sv
// Configuration register file of the sparse chunked tile store.
// Depends on sct_pkg and the sct_cfg_if interface.
module sct_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    sct_cfg_if.sink       cfg,
    output sct_pkg::cfg_t regs
);
    import sct_pkg::*;

    cfg_t regs_reg;
    cfg_t regs_next;

    // Writes are always taken.
    assign cfg.ready = 1'b1;

    // Decode a write beat into the addressed register; unknown indexes are dropped.
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CHUNK_SHIFT: regs_next.chunk_shift = cfg.data[SHIFT_W-1:0];
                CFG_COUNT_X:     regs_next.count_x     = cfg.data[CNT_W-1:0];
                CFG_COUNT_Y:     regs_next.count_y     = cfg.data[CNT_W-1:0];
                CFG_COUNT_Z:     regs_next.count_z     = cfg.data[CNT_W-1:0];
                CFG_FILL_VALUE:  regs_next.fill_value  = cfg.data[PORT_VAL_W-1:0];
                default:         regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.chunk_shift <= RST_CHUNK_SHIFT;
            regs_reg.count_x     <= RST_COUNT;
            regs_reg.count_y     <= RST_COUNT;
            regs_reg.count_z     <= RST_COUNT;
            regs_reg.fill_value  <= RST_FILL_VALUE;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

    assign regs = regs_reg;

endmodule

// File: rtl/core/sct_datapath.sv
// Datapath of the sparse chunked tile store: coordinate split, linear chunk
// index, allocation flags, tile memory and result register.
// Depends on sct_pkg and the sct_rsp_if interface.
module sct_datapath #(
    parameter int MAX_CHUNK_SHIFT = sct_pkg::DEF_MAX_CHUNK_SHIFT,
    parameter int MAX_CHUNKS      = sct_pkg::DEF_MAX_CHUNKS,
    parameter int VALUE_BITS      = sct_pkg::DEF_VALUE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sct_pkg::cfg_t                      cfg,
    input  logic                               in_cmd,
    input  logic [sct_pkg::COORD_W-1:0]        in_tile_x,
    input  logic [sct_pkg::COORD_W-1:0]        in_tile_y,
    input  logic [sct_pkg::COORD_W-1:0]        in_tile_z,
    input  logic [sct_pkg::PORT_VAL_W-1:0]     in_write_value,
    input  sct_pkg::sct_cmd_t                  cmd,
    output sct_pkg::sct_sts_t                  sts,
    sct_rsp_if.source                          rsp
);
    import sct_pkg::*;

    localparam int OFF_W   = 2 * MAX_CHUNK_SHIFT;
    localparam int CHUNK_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int ADDR_W  = CHUNK_W + OFF_W;
    localparam int DEPTH   = MAX_CHUNKS * (2 ** OFF_W);

    // Captured request.
    logic                  is_write_reg;
    logic [COORD_W-1:0]    tx_reg;
    logic [COORD_W-1:0]    ty_reg;
    logic [COORD_W-1:0]    tz_reg;
    logic [VALUE_BITS-1:0] wval_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            is_write_reg <= (in_cmd == CMD_WRITE);
            tx_reg       <= in_tile_x;
            ty_reg       <= in_tile_y;
            tz_reg       <= in_tile_z;
            wval_reg     <= VALUE_BITS'(in_write_value);
        end
    end

    // Effective chunk shift, clamped into 1..MAX_CHUNK_SHIFT.
    logic [SHIFT_W-1:0] shift_eff;

    always_comb
    begin
        if (cfg.chunk_shift == '0)
            shift_eff = SHIFT_W'(1);
        else if (cfg.chunk_shift > SHIFT_W'(MAX_CHUNK_SHIFT))
            shift_eff = SHIFT_W'(MAX_CHUNK_SHIFT);
        else
            shift_eff = cfg.chunk_shift;
    end

    // Split stage: chunk coordinates, bounds check, in-chunk offset and the
    // first half of the linear index.
    logic [COORD_W-1:0]         cx;
    logic [COORD_W-1:0]         cy;
    logic [MAX_CHUNK_SHIFT-1:0] off_mask;
    logic [MAX_CHUNK_SHIFT-1:0] rx;
    logic [MAX_CHUNK_SHIFT-1:0] ry;
    logic [OFF_W-1:0]           offset;
    logic                       oor1;
    logic [T_W-1:0]             t_val;

    always_comb
    begin
        cx       = tx_reg >> shift_eff;
        cy       = ty_reg >> shift_eff;
        off_mask = ~({MAX_CHUNK_SHIFT{1'b1}} << shift_eff);
        rx       = tx_reg[MAX_CHUNK_SHIFT-1:0] & off_mask;
        ry       = ty_reg[MAX_CHUNK_SHIFT-1:0] & off_mask;
        offset   = (OFF_W'(ry) << shift_eff) | OFF_W'(rx);
        oor1     = (cx >= COORD_W'(cfg.count_x)) || (cy >= COORD_W'(cfg.count_y))
                || (tz_reg >= COORD_W'(cfg.count_z));
        t_val    = T_W'(tz_reg[CNT_W-1:0]) * T_W'(cfg.count_y) + T_W'(cy[CNT_W-1:0]);
    end

    logic             oor1_reg;
    logic [T_W-1:0]   t_reg;
    logic [CNT_W-1:0] cx_reg;
    logic [OFF_W-1:0] off_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.split)
        begin
            oor1_reg <= oor1;
            t_reg    <= t_val;
            cx_reg   <= cx[CNT_W-1:0];
            off_reg  <= offset;
        end
    end

    // Linear index stage: finish the index, check it against capacity and
    // look up the allocation flag.
    logic [LIN_W-1:0]      lin;
    logic                  oor2;
    logic [CHUNK_W-1:0]    lin_idx;
    logic [MAX_CHUNKS-1:0] alloc_reg;

    assign lin     = LIN_W'(t_reg) * LIN_W'(cfg.count_x) + LIN_W'(cx_reg);
    assign oor2    = oor1_reg || (lin >= LIN_W'(MAX_CHUNKS));
    assign lin_idx = lin[CHUNK_W-1:0];

    logic               oor2_reg;
    logic               hit_reg;
    logic [CHUNK_W-1:0] chunk_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.lin_load)
        begin
            oor2_reg  <= oor2;
            hit_reg   <= !oor2 && alloc_reg[lin_idx];
            chunk_reg <= lin_idx;
        end
    end

    // Allocation flags and the fill sweep counter.
    logic [OFF_W-1:0] fill_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_reg    <= '0;
            fill_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.fill_start)
            begin
                alloc_reg[chunk_reg] <= 1'b1;
                fill_cnt_reg         <= '0;
            end
            else if (cmd.fill_write)
            begin
                fill_cnt_reg <= fill_cnt_reg + OFF_W'(1);
            end
        end
    end

    // Tile memory: one write or read per cycle, registered read data.
    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic [VALUE_BITS-1:0] mem_q_reg;
    logic [ADDR_W-1:0]     mem_addr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic                  mem_we;

    assign mem_addr  = {chunk_reg, (cmd.fill_write ? fill_cnt_reg : off_reg)};
    assign mem_we    = cmd.tile_write || cmd.fill_write;
    assign mem_wdata = (cmd.fill_write && (fill_cnt_reg != off_reg))
                     ? VALUE_BITS'(cfg.fill_value) : wval_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (cmd.mem_read)
            mem_q_reg <= mem[mem_addr];
    end

    // Result register; it frees as soon as the sink takes the beat.
    logic                  rsp_valid_reg;
    logic [PORT_VAL_W-1:0] rsp_value_reg;
    status_t               rsp_status_reg;
    logic [PORT_VAL_W-1:0] res_value;
    status_t               res_status;

    always_comb
    begin
        res_value  = '0;
        res_status = ST_DONE;
        if (oor2_reg)
            res_status = ST_RANGE;
        else if (!is_write_reg && !hit_reg)
            res_status = ST_UNALLOC;
        else if (!is_write_reg)
            res_value = PORT_VAL_W'(mem_q_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.push_out)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_out)
        begin
            rsp_value_reg  <= res_value;
            rsp_status_reg <= res_status;
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.read_value = rsp_value_reg;
    assign rsp.status     = rsp_status_reg;

    // Status back to the controller.
    assign sts.oor       = oor2_reg;
    assign sts.is_write  = is_write_reg;
    assign sts.alloc_hit = hit_reg;
    assign sts.fill_last = &fill_cnt_reg;
    assign sts.out_free  = !rsp_valid_reg || rsp.ready;

    // A new result never overwrites one the sink has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_out |-> (!rsp_valid_reg || rsp.ready))
        else $error("result register overwritten while still pending");

    // Only an in-range write to an unallocated chunk starts a fill.
    a_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fill_start |-> (!oor2_reg && is_write_reg && !hit_reg))
        else $error("fill started for a chunk that needs none");

    // An out-of-range access reports range status with a zero value.
    a_range_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.push_out && oor2_reg) |=> (rsp_value_reg == '0 && rsp_status_reg == ST_RANGE))
        else $error("out-of-range result carries wrong fields");

endmodule

// File: rtl/core/sct_ctrl.sv
// Controller state machine of the sparse chunked tile store: sequences the
// address stages, the memory access or allocation fill, and the result push.
// Depends on sct_pkg.
module sct_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output sct_pkg::sct_cmd_t  cmd,
    input  sct_pkg::sct_sts_t  sts
);
    import sct_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SPLIT  = 6'b000010,
        S_LIN    = 6'b000100,
        S_DECIDE = 6'b001000,
        S_FILL   = 6'b010000,
        S_RESP   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == S_IDLE);

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = S_LIN;
            end
            S_LIN:
            begin
                cmd.lin_load = 1'b1;
                state_next   = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_RESP;
                if (!sts.oor)
                begin
                    if (sts.is_write && sts.alloc_hit)
                        cmd.tile_write = 1'b1;
                    else if (sts.is_write)
                    begin
                        cmd.fill_start = 1'b1;
                        state_next     = S_FILL;
                    end
                    else if (sts.alloc_hit)
                        cmd.mem_read = 1'b1;
                end
            end
            S_FILL:
            begin
                cmd.fill_write = 1'b1;
                if (sts.fill_last)
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.push_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // An accepted beat always starts the address split.
    a_accept_split: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_SPLIT))
        else $error("accepted beat did not start address split");

    // The fill sweep runs until its last tile.
    a_fill_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL && !sts.fill_last) |=> (state_reg == S_FILL))
        else $error("fill sweep left early");

    // After a result push the block is free for the next beat.
    a_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push_out |=> (state_reg == S_IDLE))
        else $error("no return to idle after result push");

endmodule

// File: rtl/core/sparse_chunked_tile_store.sv
// A read or write of an allocated chunk, or an out-of-range access, passes through
// capture at the accepting edge, then coordinate split and linear chunk index (each
// with one registered multiply), memory access and result push. The next request
// is taken in the cycle after the push. The first write to a chunk adds a fill sweep
// over all 2^(2*MAX_CHUNK_SHIFT) tile slots of the chunk (256 by default), one tile
// per cycle through the single tile memory write port. The result register holds
// one finished beat, so a new request is accepted while a result still waits. No
// clearing pass runs after reset: allocation flags clear at once and tile contents
// are defined by the fill.
// Depends on sct_pkg, sct_ifs, sct_cfg_regs, sct_datapath and sct_ctrl.
module sparse_chunked_tile_store #(
    parameter int MAX_CHUNK_SHIFT = sct_pkg::DEF_MAX_CHUNK_SHIFT,
    parameter int MAX_CHUNKS      = sct_pkg::DEF_MAX_CHUNKS,
    parameter int VALUE_BITS      = sct_pkg::DEF_VALUE_BITS
) (
    input  logic      clk,
    input  logic      rst_n,
    sct_req_if.sink   req,
    sct_rsp_if.source rsp,
    sct_cfg_if.sink   cfg
);
    import sct_pkg::*;

    cfg_t     cfg_regs;
    sct_cmd_t cmd;
    sct_sts_t sts;

    // Configuration registers.
    sct_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (cfg_regs)
    );

    // Controller.
    sct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Datapath.
    sct_datapath #(
        .MAX_CHUNK_SHIFT (MAX_CHUNK_SHIFT),
        .MAX_CHUNKS      (MAX_CHUNKS),
        .VALUE_BITS      (VALUE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_regs),
        .in_cmd         (req.cmd),
        .in_tile_x      (req.tile_x),
        .in_tile_y      (req.tile_y),
        .in_tile_z      (req.tile_z),
        .in_write_value (req.write_value),
        .cmd            (cmd),
        .sts            (sts),
        .rsp            (rsp)
    );

endmodule
